// File: hdl/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; imported by every module of the block.
package ps2mt_pkg;

  // Header byte bit positions
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned BtnBits     = 3;

  // Configuration
  localparam int unsigned SizeBits     = 13;
  localparam int unsigned CfgAddrBits  = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam logic [SizeBits-1:0] WidthReset  = 13'd640;
  localparam logic [SizeBits-1:0] HeightReset = 13'd480;
  localparam int unsigned PosXReset   = 320;
  localparam int unsigned PosYReset   = 240;

  // Register index, taken from paddr bit 2
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // Framing phase, one-hot
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_X    = 3'b010,
    PH_Y    = 3'b100
  } phase_e;

  // One framed packet travelling from front to back
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } pkt_t;

  // Handshake between the front end and the queue
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// File: hdl/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: APB registers, front, queue, back.
// Depends on ps2mt_pkg, ps2mt_front, ps2mt_fifo and ps2mt_back.
//
//   port group | direction | contents
//   s_axis     | in        | tdata[7:0] data_byte
//   m_axis     | out       | tdata pointer_x, pointer_y, buttons, click
//   apb        | in/out    | reg 0 screen_width @0x0, reg 1 screen_height @0x4
//
// A byte is taken every cycle unless a closing byte meets a full queue; the third byte
// of a packet is written to the queue, then the pointer update fills the output register.
// Reset is asynchronous, active low; the pointer restarts at 320,240 and the
// framer hunts for a header. The two-entry queue lets bytes keep arriving while
// the output stalls; s_axis_tready drops only on a closing byte with the queue full.
module ps2_mouse_packet_tracker_top
  import ps2mt_pkg::*;
#(
  parameter int unsigned POS_BITS = 12,
  localparam int unsigned TDW = ((2 * POS_BITS + BtnBits + 1 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] data_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // from bit 0: pointer_x, pointer_y, buttons[2:0], click, zero pad
  output logic [TDW-1:0]         m_axis_tdata_o,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [CfgAddrBits-1:0] paddr_i,
  input  logic [CfgDataBits-1:0] pwdata_i,
  output logic [CfgDataBits-1:0] prdata_o,
  output logic                   pready_o
);

  logic [SizeBits-1:0] width_q, height_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;
  hs_t                 push;
  pkt_t                pkt_in, pkt_out;
  logic                full, empty, pop;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_idx  = reg_idx_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_q  <= pwdata_i[SizeBits-1:0];
        REG_HEIGHT: height_q <= pwdata_i[SizeBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata_o = CfgDataBits'(width_q);
      REG_HEIGHT: prdata_o = CfgDataBits'(height_q);
      default:    prdata_o = '0;
    endcase
  end

  ps2mt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (!full),
    .pkt_o        (pkt_in)
  );

  ps2mt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.valid && push.ready),
    .full_o  (full),
    .wdata_i (pkt_in),
    .empty_o (empty),
    .pop_i   (pop),
    .rdata_o (pkt_out)
  );

  ps2mt_back #(
    .POS_BITS (POS_BITS),
    .TDW      (TDW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pkt_i       (pkt_out),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// File: hdl/ps2mt_front.sv
// Front end: accepts mouse bytes, hunts for the header and frames packets.
// Depends on ps2mt_pkg; feeds ps2mt_fifo.
module ps2mt_front
  import ps2mt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] data_byte_i,
  output hs_t        push_o,
  input  logic       push_ready_i,
  output pkt_t       pkt_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] header_q, x_move_q;
  logic       take;

  // Only the closing byte needs room in the queue
  assign byte_ready_o = (phase_q != PH_Y) || push_ready_i;
  assign take         = byte_valid_i && byte_ready_o;

  assign push_o.valid = byte_valid_i && (phase_q == PH_Y);
  assign push_o.ready = push_ready_i;
  assign pkt_o.header = header_q;
  assign pkt_o.x_move = x_move_q;
  assign pkt_o.y_move = data_byte_i;

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      unique case (phase_q)
        PH_HEAD: phase_d = data_byte_i[HdrSyncBit] ? PH_X : PH_HEAD;
        PH_X:    phase_d = PH_Y;
        PH_Y:    phase_d = PH_HEAD;
        default: phase_d = PH_HEAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (phase_q == PH_HEAD) && data_byte_i[HdrSyncBit]) begin
      header_q <= data_byte_i;
    end
    if (take && (phase_q == PH_X)) begin
      x_move_q <= data_byte_i;
    end
  end

endmodule

// File: hdl/ps2mt_fifo.sv
// Two-entry packet queue between the framing front end and the tracking back end.
// Depends on ps2mt_pkg.
module ps2mt_fifo
  import ps2mt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  pkt_t wdata_i,
  output logic empty_o,
  input  logic pop_i,
  output pkt_t rdata_o
);

  localparam int unsigned Depth = 2;

  pkt_t       mem_q [Depth];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q + 1'(do_push);
    rptr_d  = rptr_q + 1'(do_pop);
    count_d = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: hdl/ps2mt_back.sv
// Back end: applies packet deltas to the pointer, clamps, and holds the result word.
// Depends on ps2mt_pkg; drains ps2mt_fifo.
module ps2mt_back
  import ps2mt_pkg::*;
#(
  parameter int unsigned POS_BITS = 12,
  parameter int unsigned TDW      = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  output logic                pop_o,
  input  pkt_t                pkt_i,
  input  logic [SizeBits-1:0] width_i,
  input  logic [SizeBits-1:0] height_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TDW-1:0]      out_data_o
);

  localparam int unsigned CW   = ((POS_BITS > SizeBits) ? POS_BITS : SizeBits) + 2;
  localparam int unsigned PMax = (1 << POS_BITS) - 1;
  localparam logic [POS_BITS-1:0] RstX = POS_BITS'((PMax < PosXReset) ? PMax : PosXReset);
  localparam logic [POS_BITS-1:0] RstY = POS_BITS'((PMax < PosYReset) ? PMax : PosYReset);
  localparam logic signed [CW-1:0] PosMax = CW'(PMax);

  logic [POS_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [BtnBits-1:0]  prev_btn_q;
  logic                out_valid_q;
  logic [TDW-1:0]      out_data_q, out_data_d;
  logic signed [8:0]   dx, dy;
  logic signed [CW-1:0] sum_x, sum_y, lim_x, lim_y;
  logic [BtnBits-1:0]  btn;
  logic                click;

  function automatic logic signed [CW-1:0] upper_limit(input logic [SizeBits-1:0] size);
    logic [SizeBits-1:0]  hi;
    logic signed [CW-1:0] lim;
    hi  = (size == '0) ? '0 : size - 1'b1;
    lim = $signed(CW'(hi));
    return (lim > PosMax) ? PosMax : lim;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp(input logic signed [CW-1:0] v,
                                               input logic signed [CW-1:0] lim);
    logic signed [CW-1:0] r;
    r = v;
    if (r < 0) r = '0;
    if (r > lim) r = lim;
    return r[POS_BITS-1:0];
  endfunction

  // Advance when the result slot is free or being taken this cycle
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  assign dx    = $signed({pkt_i.header[HdrXSignBit], pkt_i.x_move});
  assign dy    = $signed({pkt_i.header[HdrYSignBit], pkt_i.y_move});
  assign sum_x = $signed(CW'(pos_x_q)) + CW'(dx);
  assign sum_y = $signed(CW'(pos_y_q)) - CW'(dy);
  assign lim_x = upper_limit(width_i);
  assign lim_y = upper_limit(height_i);
  assign btn   = pkt_i.header[BtnBits-1:0];
  assign click = (btn != prev_btn_q) && btn[0];

  always_comb begin
    pos_x_d    = clamp(sum_x, lim_x);
    pos_y_d    = clamp(sum_y, lim_y);
    out_data_d = TDW'({click, btn, pos_y_d, pos_x_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= RstX;
      pos_y_q     <= RstY;
      prev_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        prev_btn_q  <= btn;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/ps2mt_checker.sv
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker_top.
module ps2mt_checker
  import ps2mt_pkg::*;
#(
  parameter int unsigned POS_BITS = 12,
  parameter int unsigned TDW      = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tready_o,
  input logic           m_axis_tvalid_o,
  input logic           m_axis_tready_i,
  input logic [TDW-1:0] m_axis_tdata_o
);

  localparam int unsigned BtnLo   = 2 * POS_BITS;
  localparam int unsigned ClickAt = 2 * POS_BITS + BtnBits;

  // Output register empties on reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result word valid during reset");

  // Input only backs up when the queue is full behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result waiting");

  // A click needs the left button down
  a_click_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[ClickAt]) |-> m_axis_tdata_o[BtnLo])
    else $error("click without left button");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result word changed");

endmodule

bind ps2_mouse_packet_tracker_top ps2mt_checker #(
  .POS_BITS (POS_BITS),
  .TDW      (TDW)
) u_ps2mt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: sim/ps2_mouse_packet_tracker_top_tb.sv
// Self-checking testbench for the PS/2 mouse packet tracker: directed bytes, then random
// packet streams under several screen sizes, checked against an in-bench pointer tracker.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker_top.
module ps2_mouse_packet_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mt_pkg::*;

  localparam int unsigned PosBits = 12;
  localparam int          PosMax  = (1 << PosBits) - 1;
  localparam int unsigned Tdw     = ((2 * PosBits + BtnBits + 1 + 7) / 8) * 8;
  localparam int          IdleLimit = 3000;

  typedef struct packed {
    logic [PosBits-1:0] x;
    logic [PosBits-1:0] y;
    logic [BtnBits-1:0] buttons;
    logic               click;
  } pointer_t;

  typedef struct packed {
    logic [7:0]         data_val;
    logic               typed;
    logic [PosBits-1:0] x;
    logic [PosBits-1:0] y;
    logic [BtnBits-1:0] buttons;
    logic               click;
  } byte_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   byte_valid;
  logic [7:0]             byte_data;
  logic                   rx_ready;
  logic                   psel, penable, pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata;

  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [Tdw-1:0]         m_axis_tdata_o;
  logic [CfgDataBits-1:0] prdata_o;
  logic                   pready_o;

  // tracker state, mirrored from the block
  phase_e             frame_phase;
  logic [7:0]         held_header;
  logic [7:0]         held_x_move;
  int                 pos_x, pos_y;
  logic [BtnBits-1:0] last_buttons;
  logic [SizeBits-1:0] screen_w, screen_h;

  pointer_t pending_pointer_q[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  bit       tx_gaps, rx_stalls;

  ps2_mouse_packet_tracker_top #(.POS_BITS(PosBits)) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (byte_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_to_screen(input int v, input logic [SizeBits-1:0] size);
    int hi;
    hi = (size == '0) ? 0 : int'(size) - 1;
    if (hi > PosMax) hi = PosMax;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Advance the framer by one byte; returns 1 when a packet completes.
  function automatic bit track_mouse_byte(input logic [7:0] b, output pointer_t res);
    int                 dx, dy;
    logic [BtnBits-1:0] btn;
    bit                 done;
    done = 1'b0;
    res  = '0;
    case (frame_phase)
      PH_X: begin
        held_x_move = b;
        frame_phase = PH_Y;
      end
      PH_Y: begin
        frame_phase = PH_HEAD;
        dx = int'(held_x_move) - (held_header[HdrXSignBit] ? 256 : 0);
        dy = int'(b) - (held_header[HdrYSignBit] ? 256 : 0);
        pos_x = clamp_to_screen(pos_x + dx, screen_w);
        pos_y = clamp_to_screen(pos_y - dy, screen_h);
        btn = held_header[BtnBits-1:0];
        res.x       = pos_x[PosBits-1:0];
        res.y       = pos_y[PosBits-1:0];
        res.buttons = btn;
        res.click   = (btn != last_buttons) && btn[0];
        last_buttons = btn;
        done = 1'b1;
      end
      default: begin
        // hunt for a header: drop anything without the sync bit
        if (b[HdrSyncBit]) begin
          held_header = b;
          frame_phase = PH_X;
        end else begin
          frame_phase = PH_HEAD;
        end
      end
    endcase
    return done;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Drive one byte at a falling edge, hold until taken, then update the tracker.
  task automatic put_byte(input logic [7:0] b, input bit typed = 1'b0,
                          input pointer_t typed_res = '0);
    pointer_t res;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    do @(posedge clk); while (!s_axis_tready_o);
    if (track_mouse_byte(b, res))
      pending_pointer_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // drift 0: random, 1: towards the far corner, 2: towards the origin
  task automatic send_packet(input int drift);
    logic [7:0] hdr, xb, yb;
    bit         xs, ys;
    hdr = 8'($urandom);
    hdr[HdrSyncBit] = 1'b1;
    if ($urandom_range(0, 9) < 4) hdr[BtnBits-1:0] = last_buttons;
    if (drift != 0 && $urandom_range(0, 9) < 7) begin
      xs = (drift == 2);
      ys = (drift == 1);
      hdr[HdrXSignBit] = xs;
      hdr[HdrYSignBit] = ys;
      xb = xs ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
      yb = ys ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
    end else begin
      xb = 8'($urandom);
      yb = 8'($urandom);
    end
    put_byte(hdr);
    put_byte(xb);
    put_byte(yb);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [CfgDataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready_o);
    if (idx == REG_WIDTH) screen_w = value[SizeBits-1:0];
    else                  screen_h = value[SizeBits-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read_check(input reg_idx_e idx);
    logic [CfgDataBits-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready_o);
    want = CfgDataBits'(idx == REG_WIDTH ? screen_w : screen_h);
    if (prdata_o !== want) note_mismatch("register readback", want, prdata_o);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, let any half-framed packet settle, then resize the screen.
  task automatic resize_screen(input logic [CfgDataBits-1:0] w, input logic [CfgDataBits-1:0] h);
    byte_valid <= 1'b0;
    while (pending_pointer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_read_check(REG_WIDTH);
    apb_read_check(REG_HEIGHT);
  endtask

  // Receiver: drop ready in random stall bursts while enabled.
  initial begin
    rx_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stalls && $urandom_range(0, 5) == 0) begin
        rx_ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pointer_t want;
    if (rst_n && m_axis_tvalid_o && rx_ready) begin
      if (pending_pointer_q.size() == 0) begin
        note_mismatch("result with nothing pending", 0, m_axis_tdata_o);
      end else begin
        want = pending_pointer_q.pop_front();
        if (m_axis_tdata_o[PosBits-1:0] !== want.x)
          note_mismatch("pointer_x", want.x, m_axis_tdata_o[PosBits-1:0]);
        if (m_axis_tdata_o[2*PosBits-1:PosBits] !== want.y)
          note_mismatch("pointer_y", want.y, m_axis_tdata_o[2*PosBits-1:PosBits]);
        if (m_axis_tdata_o[2*PosBits+BtnBits-1:2*PosBits] !== want.buttons)
          note_mismatch("buttons", want.buttons, m_axis_tdata_o[2*PosBits+BtnBits-1:2*PosBits]);
        if (m_axis_tdata_o[2*PosBits+BtnBits] !== want.click)
          note_mismatch("click", want.click, m_axis_tdata_o[2*PosBits+BtnBits]);
      end
    end
  end

  // Watchdog on handshake silence
  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_valid && s_axis_tready_o) || (m_axis_tvalid_o && rx_ready) ||
          (psel && penable && pready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    byte_row_t           directed_rows [23];
    int                  phase_w [8];
    int                  phase_h [8];
    int                  phase_drift [8];
    logic [CfgDataBits-1:0] w_word, h_word;

    rst_n      = 1'b0;
    byte_valid = 1'b0;
    byte_data  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tx_gaps    = 1'b1;
    rx_stalls  = 1'b1;

    screen_w     = WidthReset;
    screen_h     = HeightReset;
    frame_phase  = PH_HEAD;
    held_header  = '0;
    held_x_move  = '0;
    pos_x        = (PosXReset > PosMax) ? PosMax : PosXReset;
    pos_y        = (PosYReset > PosMax) ? PosMax : PosYReset;
    last_buttons = '0;

    // byte, typed?, x, y, buttons, click  (screen 640 x 480, pointer from 320,240)
    directed_rows = '{
      '{8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},  // no sync bit: dropped
      '{8'hF7, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},  // every bit but sync: dropped
      '{8'h08, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b1, 12'd320, 12'd240, 3'd0, 1'b0},  // zero move
      '{8'h09, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'hFF, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'hFF, 1'b1, 12'd575, 12'd0,   3'd1, 1'b1},  // y clamps at the top
      '{8'h3F, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b1, 12'd319, 12'd256, 3'd7, 1'b1},  // most negative deltas
      '{8'hC9, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},  // overflow bits set
      '{8'h7F, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h80, 1'b1, 12'd446, 12'd128, 3'd1, 1'b1},
      '{8'h09, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'hFF, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h01, 1'b1, 12'd639, 12'd127, 3'd1, 1'b0},  // x clamps right, held left
      '{8'h0A, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b1, 12'd639, 12'd127, 3'd2, 1'b0},  // change without left
      '{8'h1C, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h01, 1'b0, 12'd0,   12'd0,   3'd0, 1'b0},
      '{8'h00, 1'b1, 12'd384, 12'd127, 3'd4, 1'b0}
    };

    // zero size, one-pixel strips, the largest size, a shrink, a full 4096 square, random, default
    phase_w     = '{0, 1,    4096, 8191, 100, 4096, 0, 640};
    phase_h     = '{0, 4096, 1,    8191, 50,  4096, 0, 480};
    phase_drift = '{0, 1,    2,    1,    0,   2,    0, 0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apb_read_check(REG_WIDTH);
    apb_read_check(REG_HEIGHT);

    foreach (directed_rows[i])
      put_byte(directed_rows[i].data_val, directed_rows[i].typed,
               '{directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].buttons, directed_rows[i].click});

    for (int p = 0; p < 8; p++) begin
      if (p == 6) begin
        // random sizes, junk above the size field
        w_word = ($urandom & ~32'h1FFF) | $urandom_range(1, 4096);
        h_word = ($urandom & ~32'h1FFF) | $urandom_range(1, 4096);
      end else begin
        w_word = phase_w[p];
        h_word = phase_h[p];
      end
      resize_screen(w_word, h_word);
      tx_gaps   = (p != 7) && ($urandom_range(0, 3) != 0);
      rx_stalls = (p != 7) && ($urandom_range(0, 3) != 0);
      repeat (32) begin
        if ($urandom_range(0, 6) == 0) put_byte(8'($urandom));
        else                           send_packet(phase_drift[p]);
      end
    end

    byte_valid <= 1'b0;
    while (pending_pointer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hdl/ps2mt_pkg.sv
hdl/ps2mt_front.sv
hdl/ps2mt_fifo.sv
hdl/ps2mt_back.sv
hdl/ps2_mouse_packet_tracker_top.sv
hdl/ps2mt_checker.sv
sim/ps2_mouse_packet_tracker_top_tb.sv
